// ===== rtl/vrt_pkg.sv =====
// ----------------------------------------------------------------------------
// vrt_pkg
// shared types and constants of the voxel ray traversal block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vrt_pkg;

  localparam int unsigned CELL_BITS_DEF = 24;
  localparam int unsigned DIST_BITS_DEF = 32;

  localparam int unsigned AXES       = 3;
  localparam int unsigned AXIS_BITS  = 2;
  localparam int unsigned ORIG_BITS  = 32;
  localparam int unsigned ORIG_FRAC  = 8;
  localparam int unsigned DIR_BITS   = 16;
  localparam int unsigned LIM_BITS   = 16;
  localparam int unsigned LIM_SHIFT  = 8;
  localparam int unsigned OUT_BITS   = 24;
  localparam int unsigned MAG_BITS   = 16;
  localparam int unsigned FAC_BITS   = 9;

  // reciprocal numerator is 2^30, quotient needs 31 bits
  localparam int unsigned QUO_BITS   = 31;
  localparam int unsigned CNT_BITS   = $clog2(QUO_BITS);
  localparam logic [CNT_BITS-1:0] CNT_TOP = CNT_BITS'(QUO_BITS - 1);

  localparam logic [AXIS_BITS-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_BITS-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_BITS-1:0] AXIS_Z = 2'd2;

  typedef enum logic {
    KIND_START,
    KIND_ANSWER
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_PROBE = 2'd0,
    STATUS_HIT   = 2'd1,
    STATUS_MISS  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    kind_e                        kind;
    logic signed [ORIG_BITS-1:0]  origin_x;
    logic signed [ORIG_BITS-1:0]  origin_y;
    logic signed [ORIG_BITS-1:0]  origin_z;
    logic signed [DIR_BITS-1:0]   dir_x;
    logic signed [DIR_BITS-1:0]   dir_y;
    logic signed [DIR_BITS-1:0]   dir_z;
    logic        [LIM_BITS-1:0]   reach_limit;
    logic                         solid;
  } in_item_t;

  typedef struct packed {
    status_e                      status;
    logic signed [OUT_BITS-1:0]   cell_x;
    logic signed [OUT_BITS-1:0]   cell_y;
    logic signed [OUT_BITS-1:0]   cell_z;
    logic signed [OUT_BITS-1:0]   prev_x;
    logic signed [OUT_BITS-1:0]   prev_y;
    logic signed [OUT_BITS-1:0]   prev_z;
  } out_item_t;

endpackage

// ===== rtl/vrt_stream_if.sv =====
// ----------------------------------------------------------------------------
// vrt_stream_if
// valid/ready channel carrying one payload item per transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vrt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/voxel_ray_traversal.sv =====
// ----------------------------------------------------------------------------
// voxel_ray_traversal
// 3d grid ray walker: an answer to an active ray gives a result next cycle
// ray start: per axis the shared bit-serial divider, then a multiply step;
// the multiply step alone if that direction component is zero; then emit.
// one item at a time; reset clears control state and leaves the ray idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voxel_ray_traversal #(
  parameter int unsigned CELL_BITS = vrt_pkg::CELL_BITS_DEF,
  parameter int unsigned DIST_BITS = vrt_pkg::DIST_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  vrt_stream_if.sink   in_i,
  vrt_stream_if.source out_o
);

  localparam int unsigned AX  = vrt_pkg::AXES;
  localparam int unsigned LW  = (DIST_BITS > vrt_pkg::LIM_BITS + vrt_pkg::LIM_SHIFT) ?
                                DIST_BITS : vrt_pkg::LIM_BITS + vrt_pkg::LIM_SHIFT;
  localparam int unsigned SW  = (DIST_BITS > vrt_pkg::QUO_BITS) ? DIST_BITS : vrt_pkg::QUO_BITS;
  localparam int unsigned PW  = DIST_BITS + vrt_pkg::FAC_BITS;
  localparam int unsigned FRW = vrt_pkg::ORIG_FRAC;
  localparam int unsigned MW  = vrt_pkg::MAG_BITS;
  localparam int unsigned FW  = vrt_pkg::FAC_BITS;
  localparam int unsigned CW  = vrt_pkg::CNT_BITS;
  localparam int unsigned XW  = vrt_pkg::AXIS_BITS;

  vrt_pkg::state_e state_q, state_d;
  logic [XW-1:0]   ax_q, ax_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [MW-1:0]   rem_q, rem_d;
  logic [vrt_pkg::QUO_BITS-1:0] quo_q, quo_d;
  logic            active_q, active_d;
  logic            out_valid_q, out_valid_d;
  vrt_pkg::out_item_t out_q, out_d;
  logic            out_load;
  logic            out_free;
  logic            in_ready;

  logic signed [CELL_BITS-1:0] cur_q [AX];
  logic signed [CELL_BITS-1:0] cur_d [AX];
  logic signed [CELL_BITS-1:0] prev_q [AX];
  logic signed [CELL_BITS-1:0] prev_d [AX];
  logic                        neg_q [AX];
  logic                        neg_d [AX];
  logic [MW-1:0]               mag_q [AX];
  logic [MW-1:0]               mag_d [AX];
  logic [FW-1:0]               fac_q [AX];
  logic [FW-1:0]               fac_d [AX];
  logic [DIST_BITS-1:0]        delta_q [AX];
  logic [DIST_BITS-1:0]        delta_d [AX];
  logic [DIST_BITS-1:0]        bnd_q [AX];
  logic [DIST_BITS-1:0]        bnd_d [AX];
  logic [vrt_pkg::LIM_BITS-1:0] limit_q, limit_d;

  logic signed [vrt_pkg::ORIG_BITS-1:0] org [AX];
  logic signed [vrt_pkg::DIR_BITS-1:0]  dir [AX];
  logic [MW-1:0]               in_mag [AX];
  logic [FW-1:0]               in_fac [AX];

  // walker step datapath
  logic [XW-1:0]               sel;
  logic [DIST_BITS-1:0]        bnd_sel;
  logic [DIST_BITS:0]          bnd_sum;
  logic [DIST_BITS-1:0]        bnd_adv;
  logic signed [CELL_BITS-1:0] cur_step;
  logic                        in_range;

  // divider and multiplier datapath
  logic [XW-1:0]               ax_nxt;
  logic [MW:0]                 trial;
  logic                        trial_ge;
  logic [SW-1:0]               quo_ext;
  logic [DIST_BITS-1:0]        delta_new;
  logic [PW-1:0]               prod;

  assign org[0] = in_i.data.origin_x;
  assign org[1] = in_i.data.origin_y;
  assign org[2] = in_i.data.origin_z;
  assign dir[0] = in_i.data.dir_x;
  assign dir[1] = in_i.data.dir_y;
  assign dir[2] = in_i.data.dir_z;

  always_comb begin
    for (int i = 0; i < AX; i++) begin
      in_mag[i] = dir[i][vrt_pkg::DIR_BITS-1] ? MW'(-dir[i]) : MW'(dir[i]);
      in_fac[i] = dir[i][vrt_pkg::DIR_BITS-1] ? {1'b0, org[i][FRW-1:0]} :
                  FW'((1 << FRW) - int'(org[i][FRW-1:0]));
    end
  end

  // least boundary, later axis wins ties
  assign sel = (bnd_q[0] < bnd_q[1] && bnd_q[0] < bnd_q[2]) ? vrt_pkg::AXIS_X :
               (bnd_q[1] < bnd_q[2]) ? vrt_pkg::AXIS_Y : vrt_pkg::AXIS_Z;
  assign bnd_sel  = bnd_q[sel];
  assign bnd_sum  = {1'b0, bnd_sel} + {1'b0, delta_q[sel]};
  assign bnd_adv  = bnd_sum[DIST_BITS] ? {DIST_BITS{1'b1}} : bnd_sum[DIST_BITS-1:0];
  assign cur_step = neg_q[sel] ? cur_q[sel] - CELL_BITS'(1) : cur_q[sel] + CELL_BITS'(1);
  assign in_range = LW'(bnd_sel) <= LW'({limit_q, {vrt_pkg::LIM_SHIFT{1'b0}}});

  assign ax_nxt   = ax_q + XW'(1);
  assign trial    = {rem_q, cnt_q == vrt_pkg::CNT_TOP};
  assign trial_ge = trial >= {1'b0, mag_q[ax_q]};
  assign quo_ext  = SW'(quo_q);
  assign delta_new = (mag_q[ax_q] == '0) ? {DIST_BITS{1'b1}} :
                     (quo_ext > SW'({DIST_BITS{1'b1}})) ? {DIST_BITS{1'b1}} :
                     DIST_BITS'(quo_ext);
  assign prod     = PW'(fac_q[ax_q]) * PW'(delta_new);

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d  = state_q;
    ax_d     = ax_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    active_d = active_q;
    limit_d  = limit_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    neg_d    = neg_q;
    mag_d    = mag_q;
    fac_d    = fac_q;
    delta_d  = delta_q;
    bnd_d    = bnd_q;
    out_d    = out_q;
    out_load = 1'b0;
    in_ready = 1'b0;

    case (state_q)
      vrt_pkg::ST_IDLE: begin
        in_ready = out_free;
        if (in_ready && in_i.valid) begin
          if (in_i.data.kind == vrt_pkg::KIND_START) begin
            for (int i = 0; i < AX; i++) begin
              cur_d[i]  = CELL_BITS'(org[i] >>> FRW);
              prev_d[i] = CELL_BITS'(org[i] >>> FRW);
              neg_d[i]  = dir[i][vrt_pkg::DIR_BITS-1];
              mag_d[i]  = in_mag[i];
              fac_d[i]  = in_fac[i];
            end
            limit_d  = in_i.data.reach_limit;
            active_d = 1'b1;
            ax_d     = vrt_pkg::AXIS_X;
            rem_d    = '0;
            quo_d    = '0;
            cnt_d    = vrt_pkg::CNT_TOP;
            state_d  = (in_mag[0] == '0) ? vrt_pkg::ST_MUL : vrt_pkg::ST_DIV;
          end else if (active_q) begin
            out_load = 1'b1;
            if (in_i.data.solid) begin
              active_d     = 1'b0;
              out_d.status = vrt_pkg::STATUS_HIT;
              out_d.cell_x = vrt_pkg::OUT_BITS'(cur_q[0]);
              out_d.cell_y = vrt_pkg::OUT_BITS'(cur_q[1]);
              out_d.cell_z = vrt_pkg::OUT_BITS'(cur_q[2]);
              out_d.prev_x = vrt_pkg::OUT_BITS'(prev_q[0]);
              out_d.prev_y = vrt_pkg::OUT_BITS'(prev_q[1]);
              out_d.prev_z = vrt_pkg::OUT_BITS'(prev_q[2]);
            end else begin
              prev_d      = cur_q;
              cur_d[sel]  = cur_step;
              bnd_d[sel]  = bnd_adv;
              if (!in_range) begin
                active_d     = 1'b0;
                out_d.status = vrt_pkg::STATUS_MISS;
              end else begin
                out_d.status = vrt_pkg::STATUS_PROBE;
              end
              out_d.cell_x = vrt_pkg::OUT_BITS'(cur_d[0]);
              out_d.cell_y = vrt_pkg::OUT_BITS'(cur_d[1]);
              out_d.cell_z = vrt_pkg::OUT_BITS'(cur_d[2]);
              out_d.prev_x = vrt_pkg::OUT_BITS'(cur_q[0]);
              out_d.prev_y = vrt_pkg::OUT_BITS'(cur_q[1]);
              out_d.prev_z = vrt_pkg::OUT_BITS'(cur_q[2]);
            end
          end
        end
      end

      vrt_pkg::ST_DIV: begin
        rem_d = trial_ge ? MW'(trial - {1'b0, mag_q[ax_q]}) : trial[MW-1:0];
        quo_d = {quo_q[vrt_pkg::QUO_BITS-2:0], trial_ge};
        if (cnt_q == '0) begin
          state_d = vrt_pkg::ST_MUL;
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end

      vrt_pkg::ST_MUL: begin
        delta_d[ax_q] = delta_new;
        bnd_d[ax_q]   = prod[DIST_BITS+FRW-1:FRW];
        if (ax_q == vrt_pkg::AXIS_Z) begin
          state_d = vrt_pkg::ST_EMIT;
        end else begin
          ax_d    = ax_nxt;
          rem_d   = '0;
          quo_d   = '0;
          cnt_d   = vrt_pkg::CNT_TOP;
          state_d = (mag_q[ax_nxt] == '0) ? vrt_pkg::ST_MUL : vrt_pkg::ST_DIV;
        end
      end

      vrt_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_d.status = vrt_pkg::STATUS_PROBE;
          out_d.cell_x = vrt_pkg::OUT_BITS'(cur_q[0]);
          out_d.cell_y = vrt_pkg::OUT_BITS'(cur_q[1]);
          out_d.cell_z = vrt_pkg::OUT_BITS'(cur_q[2]);
          out_d.prev_x = vrt_pkg::OUT_BITS'(prev_q[0]);
          out_d.prev_y = vrt_pkg::OUT_BITS'(prev_q[1]);
          out_d.prev_z = vrt_pkg::OUT_BITS'(prev_q[2]);
          state_d      = vrt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = vrt_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vrt_pkg::ST_IDLE;
      ax_q        <= '0;
      cnt_q       <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ax_q        <= ax_d;
      cnt_q       <= cnt_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    limit_q <= limit_d;
    cur_q   <= cur_d;
    prev_q  <= prev_d;
    neg_q   <= neg_d;
    mag_q   <= mag_d;
    fac_q   <= fac_d;
    delta_q <= delta_d;
    bnd_q   <= bnd_d;
    out_q   <= out_d;
  end

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

// ===== rtl/vrt_checker.sv =====
// ----------------------------------------------------------------------------
// vrt_checker
// port-level checks of the voxel ray traversal block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vrt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input vrt_pkg::kind_e     in_kind_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input vrt_pkg::out_item_t out_data_i
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  // ray setup runs the divider or multiply states, so no transfer right after a start
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_kind_i == vrt_pkg::KIND_START |=> !in_ready_i)
    else $error("input ready during ray setup");

  // start probe cannot appear in the next cycle
  a_start_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_kind_i == vrt_pkg::KIND_START && !out_valid_i
    |=> !out_valid_i)
    else $error("start probe too early");

endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_kind_i   (in_i.data.kind),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
